FILE: sv/pps_pkg.sv
// shared types, constants and state codes for the priority scheduler
package pps_pkg;

    localparam int SLOTS = 16;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    localparam logic [15:0] TIME_MAX = 16'hFFFF;
    localparam logic [19:0] SUM_MAX  = 20'hFFFFF;

    // input item
    typedef struct packed {
        logic        func;
        logic [15:0] arrival_time;
        logic [15:0] burst_length;
        logic [7:0]  job_priority;
    } t_in;

    // result item
    typedef struct packed {
        logic [3:0]  ran_slot;
        logic        idle;
        logic        new_segment;
        logic        first_run;
        logic        finished;
        logic [15:0] time_now;
        logic [15:0] turnaround_time;
        logic [15:0] waiting_time;
        logic        all_done;
        logic [19:0] total_waiting;
        logic [19:0] total_turnaround;
        logic        rejected;
    } t_out;

    // one job slot as kept in the table memory
    typedef struct packed {
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [7:0]  prio;
        logic [15:0] remaining;
        logic        done;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // input function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic begin_tick;
        logic scan_rd;
        logic commit;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic empty;
        logic scan_last;
    } t_sts;

endpackage

FILE: sv/pps_ram.sv
// generic single write port ram with registered read
module pps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

FILE: sv/pps_ctrl.sv
// sequencer for loads and scheduling ticks
module pps_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_func,
    input  pps_pkg::t_sts i_sts,
    output pps_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    import pps_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start && i_func == FUNC_TICK) begin
                    n_state = i_sts.empty ? ST_COMMIT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_sts.scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN:  n_state = ST_COMMIT;
            ST_COMMIT: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_busy           = 1'b0;
                o_cmd.load       = i_start && (i_func == FUNC_LOAD);
                o_cmd.begin_tick = i_start && (i_func == FUNC_TICK);
            end
            ST_SCAN:   o_cmd.scan_rd = 1'b1;
            ST_DRAIN:  o_cmd = '0;
            ST_COMMIT: o_cmd.commit = 1'b1;
            default:   o_cmd = '0;
        endcase
    end

endmodule

FILE: sv/pps_dp.sv
// job table, best job search and completion arithmetic
module pps_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pps_pkg::t_cmd i_cmd,
    input  pps_pkg::t_in  i_item,
    output pps_pkg::t_sts o_sts,
    output logic          o_strobe,
    output pps_pkg::t_out o_result
);
    import pps_pkg::*;

    // control state
    logic [CNT_W-1:0] r_entry_count, n_entry_count;
    logic [CNT_W-1:0] r_done_count,  n_done_count;
    logic [15:0]      r_clock,       n_clock;
    logic             r_last_valid,  n_last_valid;
    logic [IDX_W-1:0] r_last_idx,    n_last_idx;
    logic [19:0]      r_sum_wait,    n_sum_wait;
    logic [19:0]      r_sum_tat,     n_sum_tat;
    logic [IDX_W-1:0] r_scan_idx;
    logic             r_rd_valid;
    logic [IDX_W-1:0] r_rd_idx;
    logic             r_best_valid;
    logic             r_strobe;

    // best job so far (payload)
    logic [IDX_W-1:0] r_best_idx;
    t_entry           r_best;
    t_out             r_res, n_res;

    // table memory
    t_entry           rd_entry;
    logic [ENTRY_W-1:0] rd_bits;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    t_entry           ram_wentry;

    // combinational helpers
    logic             load_reject;
    logic             eligible;
    logic             better;
    logic [15:0]      clk_next;
    logic [15:0]      rem_next;
    logic             fin;
    logic [15:0]      tat;
    logic [15:0]      wt;
    logic [20:0]      sum_wait_ext;
    logic [20:0]      sum_tat_ext;

    pps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wentry),
        .i_re    (i_cmd.scan_rd),
        .i_raddr (r_scan_idx),
        .o_rdata (rd_bits)
    );

    assign rd_entry = t_entry'(rd_bits);

    // status to the controller
    assign o_sts.empty     = (r_entry_count == '0);
    assign o_sts.scan_last = ((CNT_W'(r_scan_idx) + CNT_W'(1)) == r_entry_count);

    // scan compare: ready, unfinished, and better than the current best
    assign eligible = !rd_entry.done && (rd_entry.arrival <= r_clock);
    assign better   = !r_best_valid
                   || (rd_entry.prio < r_best.prio)
                   || ((rd_entry.prio == r_best.prio) && (rd_entry.arrival < r_best.arrival));

    // load admission
    assign load_reject = (r_entry_count >= CNT_W'(SLOTS)) || (i_item.burst_length == '0);

    // service arithmetic for the chosen job
    assign clk_next     = (r_clock == TIME_MAX) ? r_clock : r_clock + 16'd1;
    assign rem_next     = (r_best.remaining != '0) ? r_best.remaining - 16'd1 : '0;
    assign fin          = (rem_next == '0);
    assign tat          = clk_next - r_best.arrival;
    assign wt           = (tat > r_best.burst) ? tat - r_best.burst : '0;
    assign sum_wait_ext = {1'b0, r_sum_wait} + {5'd0, wt};
    assign sum_tat_ext  = {1'b0, r_sum_tat} + {5'd0, tat};

    // table write: new job on load, updated job on commit
    always_comb begin
        ram_we     = 1'b0;
        ram_waddr  = r_best_idx;
        ram_wentry = r_best;
        if (i_cmd.load) begin
            ram_we               = !load_reject;
            ram_waddr            = r_entry_count[IDX_W-1:0];
            ram_wentry.arrival   = i_item.arrival_time;
            ram_wentry.burst     = i_item.burst_length;
            ram_wentry.prio      = i_item.job_priority;
            ram_wentry.remaining = i_item.burst_length;
            ram_wentry.done      = 1'b0;
        end else if (i_cmd.commit) begin
            ram_we               = r_best_valid;
            ram_wentry.remaining = rem_next;
            ram_wentry.done      = fin;
        end
    end

    // next values of the scheduler state and the result
    always_comb begin
        n_entry_count = r_entry_count;
        n_done_count  = r_done_count;
        n_clock       = r_clock;
        n_last_valid  = r_last_valid;
        n_last_idx    = r_last_idx;
        n_sum_wait    = r_sum_wait;
        n_sum_tat     = r_sum_tat;
        n_res         = '0;
        if (i_cmd.load) begin
            if (load_reject) begin
                n_res.rejected = 1'b1;
            end else begin
                n_entry_count  = r_entry_count + CNT_W'(1);
                n_res.ran_slot = 4'(r_entry_count);
            end
        end else if (i_cmd.commit) begin
            n_clock = clk_next;
            if (!r_best_valid) begin
                n_last_valid = 1'b0;
                n_res.idle   = 1'b1;
            end else begin
                n_last_valid      = 1'b1;
                n_last_idx        = r_best_idx;
                n_res.ran_slot    = 4'(r_best_idx);
                n_res.new_segment = !r_last_valid || (r_last_idx != r_best_idx);
                n_res.first_run   = (r_best.remaining == r_best.burst);
                if (fin) begin
                    n_done_count          = r_done_count + CNT_W'(1);
                    n_sum_wait            = sum_wait_ext[20] ? SUM_MAX : sum_wait_ext[19:0];
                    n_sum_tat             = sum_tat_ext[20] ? SUM_MAX : sum_tat_ext[19:0];
                    n_res.finished        = 1'b1;
                    n_res.turnaround_time = tat;
                    n_res.waiting_time    = wt;
                end
            end
        end
        n_res.time_now         = n_clock;
        n_res.all_done         = (n_done_count == n_entry_count);
        n_res.total_waiting    = n_sum_wait;
        n_res.total_turnaround = n_sum_tat;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
            r_done_count  <= '0;
            r_clock       <= '0;
            r_last_valid  <= 1'b0;
            r_sum_wait    <= '0;
            r_sum_tat     <= '0;
            r_scan_idx    <= '0;
            r_rd_valid    <= 1'b0;
            r_best_valid  <= 1'b0;
            r_strobe      <= 1'b0;
        end else begin
            r_entry_count <= n_entry_count;
            r_done_count  <= n_done_count;
            r_clock       <= n_clock;
            r_last_valid  <= n_last_valid;
            r_sum_wait    <= n_sum_wait;
            r_sum_tat     <= n_sum_tat;
            r_rd_valid    <= i_cmd.scan_rd;
            r_strobe      <= i_cmd.load || i_cmd.commit;
            if (i_cmd.begin_tick) begin
                r_scan_idx <= '0;
            end else if (i_cmd.scan_rd) begin
                r_scan_idx <= r_scan_idx + IDX_W'(1);
            end
            if (i_cmd.begin_tick) begin
                r_best_valid <= 1'b0;
            end else if (r_rd_valid && eligible && better) begin
                r_best_valid <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_last_idx <= n_last_idx;
        if (i_cmd.scan_rd) begin
            r_rd_idx <= r_scan_idx;
        end
        if (r_rd_valid && eligible && better) begin
            r_best_idx <= r_rd_idx;
            r_best     <= rd_entry;
        end
        if (i_cmd.load || i_cmd.commit) begin
            r_res <= n_res;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_res;

endmodule

FILE: sv/preemptive_priority_scheduler.sv
// Preemptive priority scheduler top level: controller plus datapath.
// A load is taken without raising busy; its result strobes in the cycle after the transfer.
// A tick scans the loaded slots through the table memory read port, one slot per cycle:
// busy through the scan, the drain and the commit states (commit alone on an empty table),
// with the result strobed in the cycle after the commit; no new item is taken while busy.
// Synchronous active-low reset empties the table, zeroes time and totals; results never stall.
module preemptive_priority_scheduler (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  pps_pkg::t_in  i_item,
    output logic          o_strobe,
    output pps_pkg::t_out o_result
);
    import pps_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer
    pps_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_item.func),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // table and arithmetic
    pps_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (i_item),
        .o_sts    (sts),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

FILE: sv/pps_checker.sv
// port-level checks for the priority scheduler, bound to the top level
module pps_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input pps_pkg::t_in  i_item,
    input logic          o_strobe,
    input pps_pkg::t_out o_result
);
    import pps_pkg::*;

    // reset leaves the block idle with no result pending
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_strobe && !busy))
        else $error("strobe or busy after reset");

    // a load transfer gives its result on the next cycle
    a_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.func == FUNC_LOAD) |=> o_strobe)
        else $error("load result missing");

    // a tick transfer starts work and holds off the next item
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.func == FUNC_TICK) |=> (busy && !o_strobe))
        else $error("tick did not start");

    // an idle tick serves nobody
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.idle) |->
            (!o_result.finished && !o_result.first_run && !o_result.new_segment
             && o_result.ran_slot == '0))
        else $error("idle tick reports service");

    // a completed job counts as done only with waiting not above turnaround
    a_fin_times: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.finished) |->
            (o_result.waiting_time <= o_result.turnaround_time && !o_result.rejected))
        else $error("completion times inconsistent");

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (.*);
